// ----- design/mtf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtf_pkg: shared types and codes
// Item kinds, result status codes, controller states, datapath operations and
// the command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package mtf_pkg;

	localparam logic [1:0] KIND_APPEND = 2'd0;
	localparam logic [1:0] KIND_BUILD  = 2'd1;
	localparam logic [1:0] KIND_READ   = 2'd2;

	localparam logic [1:0] ST_PIXEL     = 2'd0;
	localparam logic [1:0] ST_DONE      = 2'd1;
	localparam logic [1:0] ST_NOT_BUILT = 2'd2;
	localparam logic [1:0] ST_ROW_RANGE = 2'd3;

	localparam logic CFG_IMAGE_SIZE = 1'b0;
	localparam logic CFG_BIN_COUNT  = 1'b1;

	typedef enum logic [4:0] {
		S_IDLE, S_CLR, S_ZB, S_IDX_S, S_IDX_W, S_MM, S_SPAN, S_Q_RD, S_Q_MUL,
		S_Q_S, S_Q_W, S_T_START, S_T_RD, S_T_GET, S_T_INC, S_B_DONE, S_R_CHK,
		S_R_STAT, S_R_FROM, S_R_FSET, S_R_X, S_R_XG, S_R_C, S_R_W, S_R_E
	} state_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_APPEND, OP_BUILD_INIT, OP_CLR, OP_ZERO_BIN, OP_IDX_START,
		OP_IDX_READ, OP_MINMAX, OP_SPAN, OP_PT_READ, OP_MUL, OP_Q_START,
		OP_Q_WRITE, OP_HALF_WRITE, OP_I_RESET, OP_PB_READ, OP_PREV, OP_TC_READ,
		OP_TC_INC, OP_BUILT, OP_READ_INIT, OP_EMIT_STATUS, OP_FROM_READ,
		OP_FROM_SET, OP_TC_READ_ROW, OP_PIX_START, OP_EMIT_PIX
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [1:0] code;
	} ctrl_cmd_t;

	typedef struct packed {
		logic div_busy;
		logic cnt_zero;
		logic span_zero;
		logic clr_last;
		logic idx_last;
		logic first;
		logic built;
		logic row_bad;
		logic t_zero;
		logic out_free;
	} dp_stat_t;

endpackage

// ----- design/mtf_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtf_if: channel interfaces
// Input item, result item and configuration write channels, valid/ready.
// ----------------------------------------------------------------------------
interface mtf_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [31:0] sample;
	logic [5:0]  row;
	modport source (output valid, kind, sample, row, input ready);
	modport sink (input valid, kind, sample, row, output ready);
endinterface

interface mtf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixel;
	logic [5:0] column;
	logic       last;
	logic [1:0] status;
	logic       overflowed;
	modport source (output valid, pixel, column, last, status, overflowed, input ready);
	modport sink (input valid, pixel, column, last, status, overflowed, output ready);
endinterface

interface mtf_cfg_if;
	logic       valid;
	logic       ready;
	logic       index;
	logic [6:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- design/mtf_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtf_div: radix-2 restoring divider
// One quotient bit per cycle; a division yields NUM_W quotient bits.
// ----------------------------------------------------------------------------
module mtf_div import mtf_pkg::*; #(
	parameter int NUM_W = 37,
	parameter int DEN_W = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             busy,
	output logic [NUM_W-1:0] quot
);
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] n_q;
	logic [DEN_W:0]   r_q;
	logic [DEN_W-1:0] d_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [DEN_W:0]   r_sh;
	logic             ge;
	logic [DEN_W:0]   r_nx;

	always_comb begin
		r_sh = {r_q[DEN_W-1:0], n_q[NUM_W-1]};
		ge   = r_sh >= {1'b0, d_q};
		r_nx = ge ? r_sh - {1'b0, d_q} : r_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= num;
			r_q <= '0;
			d_q <= den;
		end else if (busy_q) begin
			n_q <= {n_q[NUM_W-2:0], ge};
			r_q <= r_nx;
		end
	end

	assign busy = busy_q;
	assign quot = n_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n) start |-> !busy_q)
		else $error("divider restarted while busy");

endmodule

// ----- design/mtf_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtf_datapath: storage and arithmetic
// Sample store, resampled points, point bins, transition matrix, row totals,
// shared divider and the result register.
// ----------------------------------------------------------------------------
module mtf_datapath import mtf_pkg::*; #(
	parameter int MAX_LEN  = 1024,
	parameter int MAX_SIZE = 64,
	parameter int MAX_BINS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [31:0] sample_in,
	input  logic [5:0]  row_in,
	input  ctrl_cmd_t   cmd,
	output dp_stat_t    stat,
	mtf_out_if.source   res,
	mtf_cfg_if.sink     cfg
);
	localparam int AW    = $clog2(MAX_LEN);
	localparam int CW    = $clog2(MAX_LEN + 1);
	localparam int XW    = $clog2(MAX_SIZE);
	localparam int SW    = $clog2(MAX_SIZE + 1);
	localparam int KW    = $clog2(MAX_SIZE);
	localparam int BW    = $clog2(MAX_BINS);
	localparam int BVW   = $clog2(MAX_BINS + 1);
	localparam int TAW   = 2 * BW;
	localparam int TCD   = 1 << TAW;
	localparam int RTD   = 1 << BW;
	localparam int NUM_W = 32 + BVW;
	localparam int DEN_W = 32;
	localparam int IPW   = XW + CW;
	localparam int PNW   = KW + 9;

	logic [6:0]       image_size_q;
	logic [4:0]       bin_count_q;
	logic [CW-1:0]    cnt_q;
	logic             ovf_q;
	logic             built_q;
	logic [SW-1:0]    size_q;
	logic [BVW-1:0]   bins_q;
	logic [XW-1:0]    i_q;
	logic [TAW-1:0]   clr_q;
	logic [5:0]       row_q;

	logic [31:0]      lo_q, hi_q, span_q;
	logic [31:0]      smp_rd_q, pt_rd_q;
	logic [NUM_W-1:0] prod_s1;
	logic [BW-1:0]    pb_rd_q, prev_q, from_q;
	logic [KW-1:0]    t_q, tc_rd_q;
	logic [TAW-1:0]   tc_addr_q;
	logic [KW-1:0]    rt_q [RTD];

	logic [31:0]      smem  [MAX_LEN];
	logic [31:0]      ptmem [MAX_SIZE];
	logic [BW-1:0]    pbmem [MAX_SIZE];
	logic [KW-1:0]    tcmem [TCD];

	logic             res_valid_q;
	logic [7:0]       res_pixel_q;
	logic [5:0]       res_column_q;
	logic             res_last_q;
	logic [1:0]       res_status_q;
	logic             res_ovf_q;

	logic [SW-1:0]    size_c;
	logic [BVW-1:0]   bins_c;
	logic             div_start, div_busy;
	logic [NUM_W-1:0] div_num, div_quot;
	logic [DEN_W-1:0] div_den;
	logic [IPW-1:0]   idx_prod;
	logic [PNW-1:0]   pix_num;
	logic [31:0]      pts;
	logic [NUM_W-1:0] q_max;
	logic [BW-1:0]    q_bin;
	logic [7:0]       pix_val;
	logic             out_free;
	logic             idx_last;
	logic             emit;

	// register clamping at build time
	always_comb begin
		if (image_size_q == '0) size_c = SW'(1);
		else if (int'(image_size_q) > MAX_SIZE) size_c = SW'(MAX_SIZE);
		else size_c = SW'(image_size_q);
		if (int'(bin_count_q) < 2) bins_c = BVW'(2);
		else if (int'(bin_count_q) > MAX_BINS) bins_c = BVW'(MAX_BINS);
		else bins_c = BVW'(bin_count_q);
	end

	always_comb begin
		idx_prod  = IPW'(i_q) * IPW'(cnt_q - 1'b1);
		pix_num   = PNW'(tc_rd_q) * PNW'(510) + PNW'(t_q);
		div_start = 1'b0;
		div_num   = '0;
		div_den   = DEN_W'(1);
		case (cmd.op)
			OP_IDX_START: begin
				div_start = 1'b1;
				if (size_q != SW'(1)) begin
					div_num = NUM_W'(idx_prod);
					div_den = DEN_W'(size_q - 1'b1);
				end
			end
			OP_Q_START: begin
				div_start = 1'b1;
				div_num   = prod_s1;
				div_den   = span_q;
			end
			OP_PIX_START: begin
				div_start = 1'b1;
				div_num   = NUM_W'(pix_num);
				div_den   = DEN_W'({t_q, 1'b0});
			end
			default: ;
		endcase
	end

	mtf_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.quot   (div_quot)
	);

	always_comb begin
		pts      = smp_rd_q ^ 32'h8000_0000;
		q_max    = NUM_W'(bins_q - 1'b1);
		q_bin    = (div_quot > q_max) ? BW'(q_max) : BW'(div_quot);
		pix_val  = (t_q == '0) ? 8'd0 : ((div_quot > NUM_W'(255)) ? 8'd255 : div_quot[7:0]);
		out_free = !res_valid_q || res.ready;
		idx_last = (SW'(i_q) == size_q - 1'b1);
		emit     = (cmd.op == OP_EMIT_PIX) || (cmd.op == OP_BUILT) ||
		           (cmd.op == OP_EMIT_STATUS);
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_size_q <= 7'd64;
			bin_count_q  <= 5'd8;
			cnt_q        <= '0;
			ovf_q        <= 1'b0;
			built_q      <= 1'b0;
			size_q       <= SW'(1);
			bins_q       <= BVW'(2);
			i_q          <= '0;
			clr_q        <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			if (cfg.valid) begin
				unique case (cfg.index)
					CFG_IMAGE_SIZE: image_size_q <= cfg.data;
					CFG_BIN_COUNT:  bin_count_q  <= cfg.data[4:0];
					default: ;
				endcase
			end
			if (emit) res_valid_q <= 1'b1;
			else if (res.ready) res_valid_q <= 1'b0;
			case (cmd.op)
				OP_APPEND: begin
					if (built_q) begin
						cnt_q   <= CW'(1);
						ovf_q   <= 1'b0;
						built_q <= 1'b0;
					end else if (int'(cnt_q) < MAX_LEN) begin
						cnt_q <= cnt_q + 1'b1;
					end else begin
						ovf_q <= 1'b1;
					end
				end
				OP_BUILD_INIT: begin
					size_q <= size_c;
					bins_q <= bins_c;
					i_q    <= '0;
					clr_q  <= '0;
				end
				OP_CLR: clr_q <= clr_q + 1'b1;
				OP_ZERO_BIN, OP_MINMAX, OP_Q_WRITE, OP_HALF_WRITE, OP_PREV, OP_TC_INC,
				OP_EMIT_PIX: i_q <= i_q + 1'b1;
				OP_SPAN, OP_I_RESET, OP_READ_INIT: i_q <= '0;
				OP_BUILT: built_q <= 1'b1;
				default: ;
			endcase
		end
	end

	// payload registers and memories
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_APPEND: begin
				if (built_q) smem[0] <= sample_in;
				else if (int'(cnt_q) < MAX_LEN) smem[cnt_q[AW-1:0]] <= sample_in;
			end
			OP_BUILD_INIT: begin
				lo_q <= 32'hFFFF_FFFF;
				hi_q <= 32'h0;
				for (int k = 0; k < RTD; k++) rt_q[k] <= '0;
			end
			OP_CLR: tcmem[clr_q] <= '0;
			OP_ZERO_BIN: pbmem[i_q] <= '0;
			OP_IDX_READ: smp_rd_q <= smem[div_quot[AW-1:0]];
			OP_MINMAX: begin
				if (pts < lo_q) lo_q <= pts;
				if (pts > hi_q) hi_q <= pts;
				ptmem[i_q] <= pts;
			end
			OP_SPAN: span_q <= hi_q - lo_q;
			OP_PT_READ: pt_rd_q <= ptmem[i_q];
			OP_MUL: prod_s1 <= NUM_W'(pt_rd_q - lo_q) * NUM_W'(bins_q);
			OP_Q_WRITE: pbmem[i_q] <= q_bin;
			OP_HALF_WRITE: pbmem[i_q] <= BW'(bins_q >> 1);
			OP_PB_READ: pb_rd_q <= pbmem[i_q];
			OP_FROM_READ: pb_rd_q <= pbmem[XW'(row_q)];
			OP_PREV: prev_q <= pb_rd_q;
			OP_TC_READ: begin
				tc_rd_q   <= tcmem[{prev_q, pb_rd_q}];
				tc_addr_q <= {prev_q, pb_rd_q};
			end
			OP_TC_INC: begin
				tcmem[tc_addr_q] <= tc_rd_q + 1'b1;
				rt_q[prev_q]     <= rt_q[prev_q] + 1'b1;
				prev_q           <= tc_addr_q[BW-1:0];
			end
			OP_READ_INIT: row_q <= row_in;
			OP_FROM_SET: begin
				from_q <= pb_rd_q;
				t_q    <= rt_q[pb_rd_q];
			end
			OP_TC_READ_ROW: tc_rd_q <= tcmem[{from_q, pb_rd_q}];
			default: ;
		endcase
		case (cmd.op)
			OP_EMIT_PIX: begin
				res_pixel_q  <= pix_val;
				res_column_q <= 6'(i_q);
				res_last_q   <= idx_last;
				res_status_q <= ST_PIXEL;
				res_ovf_q    <= ovf_q;
			end
			OP_BUILT, OP_EMIT_STATUS: begin
				res_pixel_q  <= 8'd0;
				res_column_q <= 6'd0;
				res_last_q   <= 1'b1;
				res_status_q <= (cmd.op == OP_BUILT) ? ST_DONE : cmd.code;
				res_ovf_q    <= ovf_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		stat.div_busy  = div_busy;
		stat.cnt_zero  = (cnt_q == '0);
		stat.span_zero = (span_q == '0);
		stat.clr_last  = (clr_q == '1);
		stat.idx_last  = idx_last;
		stat.first     = (i_q == '0);
		stat.built     = built_q;
		stat.row_bad   = (32'(row_q) >= 32'(size_q));
		stat.t_zero    = (t_q == '0);
		stat.out_free  = out_free;
	end

	assign cfg.ready      = 1'b1;
	assign res.valid      = res_valid_q;
	assign res.pixel      = res_pixel_q;
	assign res.column     = res_column_q;
	assign res.last       = res_last_q;
	assign res.status     = res_status_q;
	assign res.overflowed = res_ovf_q;

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n) emit |-> out_free)
		else $error("result loaded over a pending item");
	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		int'(cnt_q) <= MAX_LEN)
		else $error("sample count beyond capacity");

endmodule

// ----- design/mtf_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtf_ctrl: sequencing state machine
// Accepts items, walks the build passes and row reads, issues datapath ops.
// ----------------------------------------------------------------------------
module mtf_ctrl import mtf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	mtf_in_if.sink    inp,
	input  dp_stat_t  stat,
	output ctrl_cmd_t cmd
);
	state_t     state_q, state_nx;
	logic [1:0] code_q;
	logic       acc;

	assign inp.ready = (state_q == S_IDLE);
	assign acc       = inp.valid && inp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			code_q  <= ST_NOT_BUILT;
		end else begin
			state_q <= state_nx;
			if (state_q == S_R_CHK) code_q <= stat.built ? ST_ROW_RANGE : ST_NOT_BUILT;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					case (inp.kind)
						KIND_BUILD: state_nx = S_CLR;
						KIND_READ:  state_nx = S_R_CHK;
						default: ;
					endcase
				end
			end
			S_CLR:     if (stat.clr_last) state_nx = stat.cnt_zero ? S_ZB : S_IDX_S;
			S_ZB:      if (stat.idx_last) state_nx = S_T_START;
			S_IDX_S:   state_nx = S_IDX_W;
			S_IDX_W:   if (!stat.div_busy) state_nx = S_MM;
			S_MM:      state_nx = stat.idx_last ? S_SPAN : S_IDX_S;
			S_SPAN:    state_nx = S_Q_RD;
			S_Q_RD: begin
				if (!stat.span_zero) state_nx = S_Q_MUL;
				else if (stat.idx_last) state_nx = S_T_START;
			end
			S_Q_MUL:   state_nx = S_Q_S;
			S_Q_S:     state_nx = S_Q_W;
			S_Q_W:     if (!stat.div_busy) state_nx = stat.idx_last ? S_T_START : S_Q_RD;
			S_T_START: state_nx = S_T_RD;
			S_T_RD:    state_nx = S_T_GET;
			S_T_GET: begin
				if (!stat.first) state_nx = S_T_INC;
				else state_nx = stat.idx_last ? S_B_DONE : S_T_RD;
			end
			S_T_INC:   state_nx = stat.idx_last ? S_B_DONE : S_T_RD;
			S_B_DONE:  if (stat.out_free) state_nx = S_IDLE;
			S_R_CHK:   state_nx = (!stat.built || stat.row_bad) ? S_R_STAT : S_R_FROM;
			S_R_STAT:  if (stat.out_free) state_nx = S_IDLE;
			S_R_FROM:  state_nx = S_R_FSET;
			S_R_FSET:  state_nx = S_R_X;
			S_R_X:     state_nx = S_R_XG;
			S_R_XG:    state_nx = S_R_C;
			S_R_C:     state_nx = stat.t_zero ? S_R_E : S_R_W;
			S_R_W:     if (!stat.div_busy) state_nx = S_R_E;
			S_R_E:     if (stat.out_free) state_nx = stat.idx_last ? S_IDLE : S_R_X;
			default:   state_nx = S_IDLE;
		endcase
	end

	always_comb begin
		cmd.op   = OP_NONE;
		cmd.code = code_q;
		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					case (inp.kind)
						KIND_APPEND: cmd.op = OP_APPEND;
						KIND_BUILD:  cmd.op = OP_BUILD_INIT;
						KIND_READ:   cmd.op = OP_READ_INIT;
						default: ;
					endcase
				end
			end
			S_CLR:     cmd.op = OP_CLR;
			S_ZB:      cmd.op = OP_ZERO_BIN;
			S_IDX_S:   cmd.op = OP_IDX_START;
			S_IDX_W:   if (!stat.div_busy) cmd.op = OP_IDX_READ;
			S_MM:      cmd.op = OP_MINMAX;
			S_SPAN:    cmd.op = OP_SPAN;
			S_Q_RD:    cmd.op = stat.span_zero ? OP_HALF_WRITE : OP_PT_READ;
			S_Q_MUL:   cmd.op = OP_MUL;
			S_Q_S:     cmd.op = OP_Q_START;
			S_Q_W:     if (!stat.div_busy) cmd.op = OP_Q_WRITE;
			S_T_START: cmd.op = OP_I_RESET;
			S_T_RD:    cmd.op = OP_PB_READ;
			S_T_GET:   cmd.op = stat.first ? OP_PREV : OP_TC_READ;
			S_T_INC:   cmd.op = OP_TC_INC;
			S_B_DONE:  if (stat.out_free) cmd.op = OP_BUILT;
			S_R_CHK:   cmd.op = OP_NONE;
			S_R_STAT:  if (stat.out_free) cmd.op = OP_EMIT_STATUS;
			S_R_FROM:  cmd.op = OP_FROM_READ;
			S_R_FSET:  cmd.op = OP_FROM_SET;
			S_R_X:     cmd.op = OP_PB_READ;
			S_R_XG:    cmd.op = OP_TC_READ_ROW;
			S_R_C:     if (!stat.t_zero) cmd.op = OP_PIX_START;
			S_R_W:     cmd.op = OP_NONE;
			S_R_E:     if (stat.out_free) cmd.op = OP_EMIT_PIX;
			default:   cmd.op = OP_NONE;
		endcase
	end

	a_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_EMIT_PIX && stat.idx_last) |=> state_q == S_IDLE)
		else $error("row read did not end on its last pixel");

endmodule

// ----- design/markov_transition_field_image.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// markov_transition_field_image: Markov transition field builder
// Collects Q16.16 samples, builds a binned transition matrix, serves rows
// of the transition field as 8-bit pixels.
// ----------------------------------------------------------------------------
// Usage:
//   inp carries items: kind 0 appends a sample (no result),
//   kind 1 builds the field, kind 2 reads a row, kind 3 is ignored.
//   res carries results: one status item per build or failed read,
//   one pixel item per column of the built size per good row read, last set
//   on the final one.
//   cfg writes image_size (index 0) and bin_count (index 1), always ready.
// Work: a build clears the transition matrix, then uses the shared
//   bit-serial divider at most once per point for the resample index and
//   once for the bin; a row read uses it once per pixel when the row
//   total is nonzero.
// A new item is taken only once the previous one has finished its work.
// Reset clears counts and flags; configuration returns to 64 and 8.
// If the receiver stalls, the block holds at the next result until the
// output register is taken.
// ----------------------------------------------------------------------------
module markov_transition_field_image import mtf_pkg::*; #(
	parameter int MAX_LEN  = 1024,
	parameter int MAX_SIZE = 64,
	parameter int MAX_BINS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	mtf_in_if.sink     inp,
	mtf_out_if.source  res,
	mtf_cfg_if.sink    cfg
);
	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	mtf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.inp    (inp),
		.stat   (stat),
		.cmd    (cmd)
	);

	mtf_datapath #(
		.MAX_LEN  (MAX_LEN),
		.MAX_SIZE (MAX_SIZE),
		.MAX_BINS (MAX_BINS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample_in (inp.sample),
		.row_in    (inp.row),
		.cmd       (cmd),
		.stat      (stat),
		.res       (res),
		.cfg       (cfg)
	);

endmodule

// ----- dv/mtf_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtf_checker: result predictor and scoreboard
// Watches the item, result and configuration channels. Keeps its own copy
// of the series, bins and transition matrix, predicts every result of each
// accepted item and compares the results in order, field by field.
// ----------------------------------------------------------------------------
module mtf_checker import mtf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	mtf_in_if    inp,
	mtf_out_if   res,
	mtf_cfg_if   cfg,
	output int   fail_count,
	output int   pending
);

	typedef struct packed {
		logic [7:0] pixel;
		logic [5:0] column;
		logic       last;
		logic [1:0] status;
		logic       ovf;
	} pix_item_t;

	pix_item_t   want_q[$];
	logic [31:0] series[1024];
	int unsigned series_len;
	logic [3:0]  pt_bin[64];
	int unsigned trans[16][16];
	int unsigned row_sum[16];
	logic        is_built;
	logic        dropped;
	int unsigned built_w;
	logic [6:0]  size_reg;
	logic [4:0]  bins_reg;

	assign pending = want_q.size();

	function automatic pix_item_t mk(input logic [7:0] p, input logic [5:0] c,
			input logic l, input logic [1:0] s);
		pix_item_t r;
		r.pixel = p;
		r.column = c;
		r.last = l;
		r.status = s;
		r.ovf = dropped;
		return r;
	endfunction

	task automatic add_want(input pix_item_t it);
		want_q = {want_q, it};
	endtask

	task automatic build_matrix();
		int unsigned sz, nb, idx, a, b;
		logic [31:0] pts[64];
		logic [31:0] lo, hi, span;
		logic [63:0] q;
		sz = size_reg;
		if (sz < 1) sz = 1;
		if (sz > 64) sz = 64;
		nb = bins_reg;
		if (nb < 2) nb = 2;
		if (nb > 16) nb = 16;
		if (series_len == 0) begin
			for (int i = 0; i < sz; i++) pt_bin[i] = 0;
		end else begin
			lo = '1;
			hi = '0;
			for (int i = 0; i < sz; i++) begin
				idx = (sz == 1) ? 0 : (i * (series_len - 1)) / (sz - 1);
				pts[i] = series[idx] ^ 32'h8000_0000;
				if (pts[i] < lo) lo = pts[i];
				if (pts[i] > hi) hi = pts[i];
			end
			span = hi - lo;
			for (int i = 0; i < sz; i++) begin
				if (span == 0) begin
					q = nb / 2;
				end else begin
					q = (64'(pts[i] - lo) * 64'(nb)) / 64'(span);
					if (q > nb - 1) q = nb - 1;
				end
				pt_bin[i] = q[3:0];
			end
		end
		for (int i = 0; i < 16; i++) begin
			row_sum[i] = 0;
			for (int j = 0; j < 16; j++) trans[i][j] = 0;
		end
		for (int i = 1; i < sz; i++) begin
			a = pt_bin[i-1];
			b = pt_bin[i];
			trans[a][b]++;
			row_sum[a]++;
		end
		built_w = sz;
		is_built = 1'b1;
	endtask

	task automatic predict_item(input logic [1:0] kind, input logic [31:0] smp,
			input logic [5:0] row);
		int unsigned from, t, c, p;
		case (kind)
			KIND_APPEND: begin
				if (is_built) begin
					series_len = 0;
					dropped = 1'b0;
					is_built = 1'b0;
				end
				if (series_len < 1024) begin
					series[series_len] = smp;
					series_len++;
				end else begin
					dropped = 1'b1;
				end
			end
			KIND_BUILD: begin
				build_matrix();
				add_want(mk(8'd0, 6'd0, 1'b1, ST_DONE));
			end
			KIND_READ: begin
				if (!is_built) begin
					add_want(mk(8'd0, 6'd0, 1'b1, ST_NOT_BUILT));
				end else if (row >= built_w) begin
					add_want(mk(8'd0, 6'd0, 1'b1, ST_ROW_RANGE));
				end else begin
					from = pt_bin[row];
					t = row_sum[from];
					for (int x = 0; x < built_w; x++) begin
						p = 0;
						if (t != 0) begin
							c = trans[from][pt_bin[x]];
							p = (510 * c + t) / (2 * t);
							if (p > 255) p = 255;
						end
						add_want(mk(8'(p), 6'(x), x + 1 == built_w, ST_PIXEL));
					end
				end
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		pix_item_t got, exp_item;
		if (!arst_n) begin
			want_q.delete();
			series_len = 0;
			is_built = 1'b0;
			dropped = 1'b0;
			built_w = 1;
			size_reg = 7'd64;
			bins_reg = 5'd8;
			fail_count = 0;
			for (int i = 0; i < 16; i++) begin
				row_sum[i] = 0;
				for (int j = 0; j < 16; j++) trans[i][j] = 0;
			end
		end else begin
			if (res.valid && res.ready) begin
				got = '{res.pixel, res.column, res.last, res.status, res.overflowed};
				if (want_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t unexpected result %p", $realtime, got);
				end else begin
					exp_item = want_q.pop_front();
					if (got !== exp_item) begin
						fail_count++;
						if (fail_count <= 10)
							$display("%0t mismatch: expected %p, got %p",
								$realtime, exp_item, got);
					end
				end
			end
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == CFG_IMAGE_SIZE) size_reg = cfg.data;
				else bins_reg = cfg.data[4:0];
			end
			if (inp.valid && inp.ready)
				predict_item(inp.kind, inp.sample, inp.row);
		end
	end

endmodule

// ----- dv/tb_markov_transition_field_image.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_markov_transition_field_image: block-level regression
// Directed items cover reads before a build, an empty series, a flat series,
// out-of-range rows, rebuilds and the register extremes; random series,
// builds and row reads follow with random gaps and output stalls. A checker
// module predicts and scores every result.
// ----------------------------------------------------------------------------
module tb_markov_transition_field_image;
	import mtf_pkg::*;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int         CYCLE_LIMIT = 6_000_000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   fail_count, pending;
	int   cycles = 0;
	int   gap_max = 19;
	int   stall_max = 19;
	int   n_items = 0;
	int   len;

	mtf_in_if  inp();
	mtf_out_if res();
	mtf_cfg_if cfg();

	markov_transition_field_image DUT (.clk(clk), .arst_n(arst_n),
		.inp(inp), .res(res), .cfg(cfg));

	mtf_checker u_checker (.clk(clk), .arst_n(arst_n), .inp(inp), .res(res),
		.cfg(cfg), .fail_count(fail_count), .pending(pending));

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		inp.valid = 1'b0;
		inp.kind = KIND_APPEND;
		inp.sample = '0;
		inp.row = '0;
		res.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = CFG_IMAGE_SIZE;
		cfg.data = '0;
	end

	// result side: random stall before each item
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			n = $urandom_range(0, stall_max);
			if (n != 0) begin
				res.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			res.ready <= 1'b1;
			do @(posedge clk); while (!(res.valid && res.ready));
		end
	end

	task automatic send(input logic [1:0] kind, input logic [31:0] smp,
			input logic [5:0] row);
		int n;
		n = $urandom_range(0, gap_max);
		if (n != 0) begin
			inp.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		inp.valid <= 1'b1;
		inp.kind <= kind;
		inp.sample <= smp;
		inp.row <= row;
		do @(posedge clk); while (!(inp.valid && inp.ready));
		if (kind != KIND_UNUSED) n_items++;
	endtask

	task automatic settle();
		inp.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic set_reg(input logic idx, input logic [6:0] val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		do @(posedge clk); while (!(cfg.valid && cfg.ready));
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		logic [31:0] base;
		int          sz;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: not built, empty series, range errors
		send(KIND_READ, 32'd0, 6'd0);
		send(KIND_UNUSED, 32'hFFFF_FFFF, 6'd63);
		settle();
		set_reg(CFG_IMAGE_SIZE, 7'd4);
		set_reg(CFG_BIN_COUNT, 7'd0);
		send(KIND_BUILD, 32'd0, 6'd0);
		send(KIND_READ, 32'd0, 6'd3);
		send(KIND_READ, 32'd0, 6'd4);
		send(KIND_READ, 32'd0, 6'd63);
		// extremes and a flat series, rebuild with other registers
		send(KIND_APPEND, 32'h8000_0000, 6'd0);
		send(KIND_APPEND, 32'h7FFF_FFFF, 6'd0);
		send(KIND_APPEND, 32'h0000_0000, 6'd0);
		send(KIND_READ, 32'd0, 6'd0);
		send(KIND_BUILD, 32'd0, 6'd0);
		send(KIND_READ, 32'd0, 6'd1);
		settle();
		set_reg(CFG_IMAGE_SIZE, 7'd0);
		set_reg(CFG_BIN_COUNT, 7'd31);
		send(KIND_BUILD, 32'd0, 6'd0);
		send(KIND_READ, 32'd0, 6'd0);
		send(KIND_READ, 32'd0, 6'd1);
		settle();
		set_reg(CFG_IMAGE_SIZE, 7'd5);
		set_reg(CFG_BIN_COUNT, 7'd16);
		for (int i = 0; i < 3; i++) send(KIND_APPEND, 32'h0001_8000, 6'd0);
		send(KIND_BUILD, 32'd0, 6'd0);
		send(KIND_READ, 32'd0, 6'd2);
		settle();
		// back-to-back series, full size, fewest bins
		set_reg(CFG_IMAGE_SIZE, 7'd127);
		set_reg(CFG_BIN_COUNT, 7'd1);
		gap_max = 0;
		for (int i = 0; i < 40; i++) send(KIND_APPEND, $urandom(), 6'd0);
		gap_max = 19;
		send(KIND_BUILD, 32'd0, 6'd0);
		send(KIND_READ, 32'd0, 6'd63);
		settle();
		set_reg(CFG_IMAGE_SIZE, 7'd64);
		set_reg(CFG_BIN_COUNT, 7'd16);
		send(KIND_BUILD, 32'd0, 6'd0);
		send(KIND_READ, 32'd0, 6'd0);
		settle();

		// random: series, build, row reads; some noise
		while (n_items < 180) begin
			gap_max = ($urandom_range(0, 3) == 0) ? 0 : 19;
			stall_max = ($urandom_range(0, 3) == 0) ? 0 : 19;
			if ($urandom_range(0, 7) == 0) sz = $urandom_range(0, 127);
			else sz = $urandom_range(1, 12);
			set_reg(CFG_IMAGE_SIZE, 7'(sz));
			set_reg(CFG_BIN_COUNT, 7'($urandom_range(0, 31)));
			len = $urandom_range(1, 20);
			base = $urandom();
			for (int i = 0; i < len; i++) begin
				case ($urandom_range(0, 3))
					0: send(KIND_APPEND, base, 6'd0);
					1: send(KIND_APPEND, base + $urandom_range(0, 255), 6'd0);
					default: send(KIND_APPEND, $urandom(), 6'd0);
				endcase
			end
			if ($urandom_range(0, 7) == 0) send(KIND_READ, 32'd0, 6'($urandom()));
			if ($urandom_range(0, 7) == 0) send(KIND_UNUSED, $urandom(), 6'($urandom()));
			send(KIND_BUILD, 32'd0, 6'd0);
			if ($urandom_range(0, 5) == 0) send(KIND_BUILD, 32'd0, 6'd0);
			for (int r = $urandom_range(1, 4); r > 0; r--) begin
				if ($urandom_range(0, 3) == 0) send(KIND_READ, 32'd0, 6'($urandom()));
				else send(KIND_READ, 32'd0, 6'($urandom_range(0, 11)));
			end
			settle();
		end

		settle();
		repeat (100) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// ----- files.f -----
design/mtf_pkg.sv
design/mtf_if.sv
design/mtf_div.sv
design/mtf_datapath.sv
design/mtf_ctrl.sv
design/markov_transition_field_image.sv
dv/mtf_checker.sv
dv/tb_markov_transition_field_image.sv
